[hw/rtl/tdc_pkg.sv]
// Shared types and constants for the time-of-day clock with button set.
package tdc_pkg;

  localparam int TICK_W       = 7;
  localparam int HOLD_W       = 8;
  localparam int HOUR_W       = 5;
  localparam int MIN_W        = 6;
  localparam int SEC_W        = 6;
  localparam int MODE_W       = 2;
  localparam int MASK_W       = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam int TICKS_PER_SECOND_DEF = 100;

  localparam logic [SEC_W-1:0]  SEC_LAST  = SEC_W'(59);
  localparam logic [MIN_W-1:0]  MIN_LAST  = MIN_W'(59);
  localparam logic [HOUR_W-1:0] HOUR_LAST = HOUR_W'(23);

  localparam logic [HOLD_W-1:0] HOLD_DELAY_RST    = HOLD_W'(100);
  localparam logic [HOLD_W-1:0] REPEAT_PERIOD_RST = HOLD_W'(20);
  localparam logic [HOLD_W-1:0] HOLD_SAT          = '1;

  // Register index, taken from paddr[2].
  localparam logic REG_HOLD_DELAY    = 1'b0;
  localparam logic REG_REPEAT_PERIOD = 1'b1;

  localparam logic [MODE_W-1:0] MODE_HOURS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MINUTES = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SECONDS = 2'd2;
  localparam logic [MODE_W-1:0] MODE_STOP    = 2'd3;

  typedef struct packed {
    logic [HOLD_W-1:0] hold_delay;
    logic [HOLD_W-1:0] repeat_period;
  } cfg_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
    logic              run_flag;
    logic [MASK_W-1:0] change_mask;
  } res_t;

endpackage

[hw/rtl/tdc_cfg_regs.sv]
// Configuration register file with an APB-style access port.
module tdc_cfg_regs
  import tdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [HOLD_W-1:0] hold_delay_r;
  logic [HOLD_W-1:0] repeat_period_r;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_delay_r    <= HOLD_DELAY_RST;
      repeat_period_r <= REPEAT_PERIOD_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_HOLD_DELAY:    hold_delay_r    <= pwdata[HOLD_W-1:0];
        REG_REPEAT_PERIOD: repeat_period_r <= pwdata[HOLD_W-1:0];
        default:           hold_delay_r    <= hold_delay_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HOLD_DELAY:    prdata = CFG_DATA_W'(hold_delay_r);
      REG_REPEAT_PERIOD: prdata = CFG_DATA_W'(repeat_period_r);
      default:           prdata = '0;
    endcase
  end

  assign cfg.hold_delay    = hold_delay_r;
  assign cfg.repeat_period = repeat_period_r;

endmodule

[hw/rtl/tdc_core.sv]
// Time counter cascade, set-button state machine and result register.
module tdc_core
  import tdc_pkg::*;
#(
  parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              set_pressed,
  input  logic [MODE_W-1:0] mode,
  input  cfg_t              cfg,
  output res_t              res
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PRESS = 2'd1,
    PH_HOLD  = 2'd2
  } phase_t;

  localparam logic [TICK_W-1:0] TICK_TOP = TICK_W'(TICKS_PER_SECOND);

  phase_t            phase_r, phase_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [SEC_W-1:0]  sec_r, sec_nxt;
  logic [MIN_W-1:0]  min_r, min_nxt;
  logic [HOUR_W-1:0] hour_r, hour_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic              run_r, run_nxt;
  res_t              res_r, res_nxt;

  logic [TICK_W-1:0] tick_inc;
  logic [HOLD_W-1:0] hold_inc;
  logic [MASK_W-1:0] mask;
  logic              sec_carry;
  logic              step_s;
  logic              toggle_s;

  always_comb begin
    // Clock cascade runs first; button edits land on the cascaded values.
    tick_inc  = tick_r + TICK_W'(1);
    sec_carry = (tick_inc >= TICK_TOP);
    tick_nxt  = sec_carry ? '0 : tick_inc;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    mask      = '0;
    if (sec_carry) begin
      mask[0] = 1'b1;
      if (sec_r >= SEC_LAST) begin
        sec_nxt = '0;
        mask[1] = 1'b1;
        if (min_r >= MIN_LAST) begin
          min_nxt  = '0;
          mask[2]  = 1'b1;
          hour_nxt = (hour_r >= HOUR_LAST) ? '0 : hour_r + HOUR_W'(1);
        end else begin
          min_nxt = min_r + MIN_W'(1);
        end
      end else begin
        sec_nxt = sec_r + SEC_W'(1);
      end
    end

    hold_inc  = (hold_r != HOLD_SAT) ? hold_r + HOLD_W'(1) : hold_r;
    phase_nxt = phase_r;
    hold_nxt  = hold_r;
    step_s    = 1'b0;
    toggle_s  = 1'b0;
    // A release always wins over the hold or repeat timer in the same tick.
    unique case (phase_r)
      PH_PRESS: begin
        if (!set_pressed) begin
          phase_nxt = PH_IDLE;
          hold_nxt  = '0;
          step_s    = 1'b1;
        end else if (hold_inc >= cfg.hold_delay) begin
          phase_nxt = PH_HOLD;
          hold_nxt  = '0;
        end else begin
          hold_nxt = hold_inc;
        end
      end
      PH_HOLD: begin
        if (!set_pressed) begin
          phase_nxt = PH_IDLE;
          hold_nxt  = '0;
          toggle_s  = (mode == MODE_STOP);
        end else if (hold_inc >= cfg.repeat_period) begin
          hold_nxt = '0;
          step_s   = (mode != MODE_STOP);
        end else begin
          hold_nxt = hold_inc;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (set_pressed) begin
          phase_nxt = PH_PRESS;
          hold_nxt  = '0;
        end
      end
    endcase

    if (step_s) begin
      unique case (mode)
        MODE_HOURS:   hour_nxt = (hour_nxt >= HOUR_LAST) ? '0 : hour_nxt + HOUR_W'(1);
        MODE_MINUTES: min_nxt  = (min_nxt >= MIN_LAST) ? '0 : min_nxt + MIN_W'(1);
        MODE_SECONDS: sec_nxt  = (sec_nxt >= SEC_LAST) ? '0 : sec_nxt + SEC_W'(1);
        default:      toggle_s = 1'b1;
      endcase
    end
    run_nxt = run_r ^ toggle_s;

    res_nxt.hours       = hour_nxt;
    res_nxt.minutes     = min_nxt;
    res_nxt.seconds     = sec_nxt;
    res_nxt.run_flag    = run_nxt;
    res_nxt.change_mask = (mode == MODE_STOP) ? '0 : mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      sec_r   <= '0;
      min_r   <= '0;
      hour_r  <= '0;
      hold_r  <= '0;
      run_r   <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      sec_r   <= sec_nxt;
      min_r   <= min_nxt;
      hour_r  <= hour_nxt;
      hold_r  <= hold_nxt;
      run_r   <= run_nxt;
      res_r   <= res_nxt;
    end
  end

  assign res = res_r;

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sec_r <= SEC_LAST) && (min_r <= MIN_LAST) && (hour_r <= HOUR_LAST))
    else $error("time counters out of range");

  a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
    tick_r < TICK_TOP)
    else $error("sub-second counter reached its top");

  a_idle_hold_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (hold_r == '0))
    else $error("hold counter not cleared while idle");

  a_stop_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (mode == MODE_STOP)) |=> (res_r.change_mask == '0))
    else $error("change mask set in stopwatch mode");

  a_run_only_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (mode != MODE_STOP)) |=> (run_r == $past(run_r)))
    else $error("run flag toggled outside stopwatch mode");

endmodule

[hw/rtl/time_of_day_clock_with_button_set_top.sv]
// Top level of the time-of-day clock with button set: handshake and output register.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-----------------------------------------
//  in_     | to block  | in_valid/stall   | in_set_pressed, in_mode
//  out_    | from block| out_valid/stall  | out_hours, out_minutes, out_seconds,
//          |           |                  | out_run_flag, out_change_mask
//  cfg     | to block  | psel/penable     | paddr, pwdata, prdata (hold_delay, repeat_period)
//
// One item per cycle unless a held result is stalled: each tick updates all counters and
// the button state machine in a single pass, and its result appears in the output register
// in the cycle after it is accepted. in_stall is high only while a held result waits and
// out_stall is high, so an item is taken in the same cycle the previous result leaves. Reset
// is synchronous; the block accepts items as soon as rst_n is high.
module time_of_day_clock_with_button_set_top
  import tdc_pkg::*;
#(
  parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_set_pressed,
  input  logic [MODE_W-1:0]     in_mode,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [HOUR_W-1:0]     out_hours,
  output logic [MIN_W-1:0]      out_minutes,
  output logic [SEC_W-1:0]      out_seconds,
  output logic                  out_run_flag,
  output logic [MASK_W-1:0]     out_change_mask,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;
  res_t res;
  logic adv;
  logic out_valid_r, out_valid_nxt;

  assign in_stall      = out_valid_r & out_stall;
  assign adv           = in_valid & ~in_stall;
  assign out_valid_nxt = adv | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  tdc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tdc_core #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .set_pressed (in_set_pressed),
    .mode        (in_mode),
    .cfg         (cfg),
    .res         (res)
  );

  assign out_valid       = out_valid_r;
  assign out_hours       = res.hours;
  assign out_minutes     = res.minutes;
  assign out_seconds     = res.seconds;
  assign out_run_flag    = res.run_flag;
  assign out_change_mask = res.change_mask;

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("accepted item produced no result");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !adv)
    else $error("item accepted while a result is held");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !adv) |=> !out_valid_r)
    else $error("result repeated after it was taken");

endmodule

[tb/time_of_day_clock_with_button_set_top_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the time-of-day clock with button set.
module time_of_day_clock_with_button_set_top_test;
  import tdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {
    BTN_IDLE  = 2'd0,
    BTN_PRESS = 2'd1,
    BTN_HOLD  = 2'd2
  } btn_phase_t;

  // Predicts the displayed time for every tick item and checks the block's results.
  class time_predictor;
    logic [HOLD_W-1:0] hold_delay;
    logic [HOLD_W-1:0] repeat_period;
    logic [TICK_W-1:0] tick_cnt;
    logic [SEC_W-1:0]  sec_cnt;
    logic [MIN_W-1:0]  min_cnt;
    logic [HOUR_W-1:0] hour_cnt;
    btn_phase_t        btn_phase;
    logic [HOLD_W-1:0] held_ticks;
    logic              running;
    res_t              expected_times[$];
    int                mismatches;
    int                checked;
    int                rollovers[MASK_W];

    function new();
      hold_delay    = HOLD_DELAY_RST;
      repeat_period = REPEAT_PERIOD_RST;
      tick_cnt      = '0;
      sec_cnt       = '0;
      min_cnt       = '0;
      hour_cnt      = '0;
      btn_phase     = BTN_IDLE;
      held_ticks    = '0;
      running       = 1'b0;
      mismatches    = 0;
      checked       = 0;
      foreach (rollovers[i]) rollovers[i] = 0;
    endfunction

    function void write_reg(logic idx, logic [HOLD_W-1:0] value);
      if (idx == REG_HOLD_DELAY) hold_delay = value;
      else repeat_period = value;
    endfunction

    // Button edits wrap the selected field with no carry into the next one; in stop mode they toggle the run flag.
    function void edit_field(logic [MODE_W-1:0] mode);
      case (mode)
        MODE_HOURS:   hour_cnt = (hour_cnt >= HOUR_LAST) ? '0 : hour_cnt + HOUR_W'(1);
        MODE_MINUTES: min_cnt = (min_cnt >= MIN_LAST) ? '0 : min_cnt + MIN_W'(1);
        MODE_SECONDS: sec_cnt = (sec_cnt >= SEC_LAST) ? '0 : sec_cnt + SEC_W'(1);
        default:      running = ~running;
      endcase
    endfunction

    function void note_tick(logic pressed, logic [MODE_W-1:0] mode);
      res_t              want;
      logic [MASK_W-1:0] mask;
      mask = '0;
      tick_cnt = tick_cnt + TICK_W'(1);
      if (tick_cnt >= TICK_W'(TICKS_PER_SECOND_DEF)) begin
        tick_cnt = '0;
        mask[0] = 1'b1;
        if (sec_cnt >= SEC_LAST) begin
          sec_cnt = '0;
          mask[1] = 1'b1;
          if (min_cnt >= MIN_LAST) begin
            min_cnt = '0;
            mask[2] = 1'b1;
            hour_cnt = (hour_cnt >= HOUR_LAST) ? '0 : hour_cnt + HOUR_W'(1);
          end else begin
            min_cnt = min_cnt + MIN_W'(1);
          end
        end else begin
          sec_cnt = sec_cnt + SEC_W'(1);
        end
      end

      if (btn_phase != BTN_IDLE && held_ticks != HOLD_SAT) held_ticks = held_ticks + HOLD_W'(1);
      // A release always wins over a timer expiring in the same tick.
      case (btn_phase)
        BTN_PRESS: begin
          if (!pressed) begin
            btn_phase  = BTN_IDLE;
            held_ticks = '0;
            edit_field(mode);
          end else if (held_ticks >= hold_delay) begin
            btn_phase  = BTN_HOLD;
            held_ticks = '0;
          end
        end
        BTN_HOLD: begin
          if (!pressed) begin
            btn_phase  = BTN_IDLE;
            held_ticks = '0;
            if (mode == MODE_STOP) running = ~running;
          end else if (held_ticks >= repeat_period) begin
            held_ticks = '0;
            if (mode != MODE_STOP) edit_field(mode);
          end
        end
        default: begin
          btn_phase = BTN_IDLE;
          if (pressed) begin
            btn_phase  = BTN_PRESS;
            held_ticks = '0;
          end
        end
      endcase

      if (mode == MODE_STOP) mask = '0;
      for (int i = 0; i < MASK_W; i++) if (mask[i]) rollovers[i]++;
      want.hours       = hour_cnt;
      want.minutes     = min_cnt;
      want.seconds     = sec_cnt;
      want.run_flag    = running;
      want.change_mask = mask;
      expected_times.push_back(want);
    endfunction

    function void check_time(res_t got);
      res_t want;
      if (expected_times.size() == 0) begin
        $error("result with no item outstanding: %0d:%0d:%0d", got.hours, got.minutes,
               got.seconds);
        mismatches++;
        return;
      end
      want = expected_times.pop_front();
      checked++;
      if (got.hours !== want.hours) begin
        $error("hours: expected %0d, got %0d", want.hours, got.hours);
        mismatches++;
      end
      if (got.minutes !== want.minutes) begin
        $error("minutes: expected %0d, got %0d", want.minutes, got.minutes);
        mismatches++;
      end
      if (got.seconds !== want.seconds) begin
        $error("seconds: expected %0d, got %0d", want.seconds, got.seconds);
        mismatches++;
      end
      if (got.run_flag !== want.run_flag) begin
        $error("run_flag: expected %0d, got %0d", want.run_flag, got.run_flag);
        mismatches++;
      end
      if (got.change_mask !== want.change_mask) begin
        $error("change_mask: expected %0d, got %0d", want.change_mask, got.change_mask);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_set_pressed;
  logic [MODE_W-1:0]     in_mode;
  logic                  out_valid;
  logic                  out_stall;
  logic [HOUR_W-1:0]     out_hours;
  logic [MIN_W-1:0]      out_minutes;
  logic [SEC_W-1:0]      out_seconds;
  logic                  out_run_flag;
  logic [MASK_W-1:0]     out_change_mask;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  time_predictor clock_pred = new();
  bit            idling_on;
  int            ticks_sent;
  int            settings_used;
  int            quiet_cycles;

  time_of_day_clock_with_button_set_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_set_pressed  (in_set_pressed),
    .in_mode         (in_mode),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hours       (out_hours),
    .out_minutes     (out_minutes),
    .out_seconds     (out_seconds),
    .out_run_flag    (out_run_flag),
    .out_change_mask (out_change_mask),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      clock_pred.check_time({out_hours, out_minutes, out_seconds, out_run_flag,
                             out_change_mask});
  end

  // Counts cycles in which neither channel nor the register port moves anything.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
        || (psel && penable && pready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("time_of_day_clock_with_button_set_top regression: fail");
        $finish;
      end
    end
  end

  // Receiver stalls in random bursts, which start only while idling is enabled.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        stall_left = $urandom_range(0, 11);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Entered and left at a falling edge.
  task automatic send_tick(input logic pressed, input logic [MODE_W-1:0] mode);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_set_pressed = pressed;
    in_mode        = mode;
    do @(posedge clk); while (in_stall !== 1'b0);
    clock_pred.note_tick(pressed, mode);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (clock_pred.expected_times.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Writes one register, then reads it back.
  task automatic set_register(input logic idx, input logic [HOLD_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = CFG_DATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    clock_pred.write_reg(idx, value);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== CFG_DATA_W'(value)) begin
      $error("%s: expected %0d, got %0d", (idx == REG_HOLD_DELAY) ? "hold_delay" :
             "repeat_period", value, prdata);
      clock_pred.mismatches++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic configure(input logic [HOLD_W-1:0] hd, input logic [HOLD_W-1:0] rp);
    wait_drained();
    set_register(REG_HOLD_DELAY, hd);
    set_register(REG_REPEAT_PERIOD, rp);
    settings_used++;
  endtask

  // Holds the button in the given mode until the field reads target or the guard expires, then lets go.
  task automatic preset_field(input logic [MODE_W-1:0] mode, input int target);
    int guard;
    int now_val;
    guard = 0;
    forever begin
      case (mode)
        MODE_HOURS:   now_val = clock_pred.hour_cnt;
        MODE_MINUTES: now_val = clock_pred.min_cnt;
        default:      now_val = clock_pred.sec_cnt;
      endcase
      if (now_val == target || guard == 200) break;
      send_tick(1'b1, mode);
      guard++;
    end
    send_tick(1'b0, mode);
  endtask

  // Mostly complete presses of assorted lengths, plus button noise and quiet stretches.
  task automatic run_mix(input int budget);
    int                stop_at;
    int                kind;
    int                lim;
    logic [MODE_W-1:0] mode;
    stop_at = ticks_sent + budget;
    while (ticks_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      mode = MODE_W'($urandom_range(0, 3));
      if (kind < 70) begin
        repeat ($urandom_range(0, 4)) send_tick(1'b0, mode);
        if (kind < 35) lim = 3;
        else if (kind < 55) lim = int'(clock_pred.hold_delay) + 3;
        else lim = int'(clock_pred.hold_delay) + 4 * int'(clock_pred.repeat_period) + 4;
        if (lim > 300) lim = 300;
        // The mode occasionally changes while the button is down.
        repeat ($urandom_range(1, lim))
          send_tick(1'b1, ($urandom_range(0, 5) == 0) ? MODE_W'($urandom_range(0, 3)) : mode);
        send_tick(1'b0, mode);
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 8)) send_tick(1'($urandom), MODE_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 30)) send_tick(1'b0, mode);
      end
    end
  endtask

  // Reconfigures, holds the button long enough to reach auto-repeat once, then mixes.
  task automatic run_phase(input logic [HOLD_W-1:0] hd, input logic [HOLD_W-1:0] rp,
                           input int budget);
    logic [MODE_W-1:0] mode;
    configure(hd, rp);
    idling_on = ($urandom_range(0, 3) != 0);
    mode = MODE_W'($urandom_range(0, 3));
    repeat (int'(hd) + int'(rp) + 3) send_tick(1'b1, mode);
    send_tick(1'b0, mode);
    run_mix(budget);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_set_pressed = 1'b0;
    in_mode        = MODE_HOURS;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    idling_on      = 1'b1;
    ticks_sent     = 0;
    settings_used  = 1;
    quiet_cycles   = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Short press in every mode under the reset register values.
    send_tick(1'b0, MODE_HOURS);
    for (int m = 0; m < 4; m++) begin
      send_tick(1'b1, MODE_W'(m));
      send_tick(1'b0, MODE_W'(m));
    end
    // The mode at release decides what the press does.
    send_tick(1'b1, MODE_HOURS);
    send_tick(1'b0, MODE_STOP);
    send_tick(1'b1, MODE_STOP);
    send_tick(1'b1, MODE_STOP);
    send_tick(1'b0, MODE_SECONDS);
    repeat (4) send_tick(1'b0, MODE_STOP);

    // Zero registers make every held tick in the hold phase a step: walk to 23:59:59 and roll the day over.
    configure('0, '0);
    preset_field(MODE_HOURS, 23);
    preset_field(MODE_MINUTES, 59);
    preset_field(MODE_SECONDS, 59);
    repeat (105) send_tick(1'b0, MODE_W'($urandom_range(0, 2)));
    run_mix(30);

    run_phase(HOLD_SAT, HOLD_SAT, 10);
    run_phase(8'd1, 8'd1, 30);
    run_phase(HOLD_W'($urandom_range(2, 40)), HOLD_W'($urandom_range(1, 15)), 30);

    // Reset values again, with both sides running flat out.
    configure(HOLD_DELAY_RST, REPEAT_PERIOD_RST);
    idling_on = 1'b0;
    run_mix(60);

    wait_drained();
    repeat (4) @(negedge clk);
    $display("Sent %0d ticks under %0d register settings; %0d results checked.",
             ticks_sent, settings_used, clock_pred.checked);
    $display("Rollovers flagged: %0d seconds, %0d minutes, %0d hours.",
             clock_pred.rollovers[0], clock_pred.rollovers[1], clock_pred.rollovers[2]);
    if (clock_pred.mismatches == 0 && clock_pred.expected_times.size() == 0) begin
      $display("time_of_day_clock_with_button_set_top regression: pass");
    end else begin
      $display("time_of_day_clock_with_button_set_top regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/tdc_pkg.sv
hw/rtl/tdc_cfg_regs.sv
hw/rtl/tdc_core.sv
hw/rtl/time_of_day_clock_with_button_set_top.sv
tb/time_of_day_clock_with_button_set_top_test.sv
